// ===== hw/rtl/rapc_pkg.sv =====
// Shared types and constants for the relay actuator position controller.
// No dependencies; used by rapc_core and relay_actuator_position_control_top.
`default_nettype none

package rapc_pkg;

    // Command codes carried in the input tuser field.
    typedef enum logic [2:0] {
        MODE_TICK  = 3'd0,
        MODE_PULSE = 3'd1,
        MODE_MOVE  = 3'd2,
        MODE_STOP  = 3'd3,
        MODE_LOAD  = 3'd4
    } mode_t;

    // Direction of the current move.
    typedef enum logic [1:0] {
        DIR_IDLE = 2'd0,
        DIR_UP   = 2'd1,
        DIR_DOWN = 2'd2
    } dir_t;

    // Configuration register indexes.
    typedef enum logic [1:0] {
        REG_MIN_LIMIT = 2'd0,
        REG_MAX_LIMIT = 2'd1,
        REG_TIMEOUT   = 2'd2
    } reg_idx_t;

    localparam logic [15:0] RESET_MIN_LIMIT = 16'd300;
    localparam logic [15:0] RESET_MAX_LIMIT = 16'd6100;
    localparam logic [15:0] RESET_TIMEOUT   = 16'd1500;
    localparam logic [15:0] RESET_POSITION  = 16'd1200;

    // Configuration as seen by the step logic.
    typedef struct packed {
        logic [15:0] min_limit;
        logic [15:0] max_limit;
        logic [15:0] stop_timeout_ms;
    } cfg_t;

    // Controller state.
    typedef struct packed {
        logic [15:0] base_position;
        logic [15:0] pulse_count;
        logic [15:0] compare_count;
        dir_t        move_dir;
        logic        coasting;
        logic [15:0] coast_timer;
        logic [7:0]  overshoot_up;
        logic [7:0]  overshoot_down;
    } state_t;

    // One result beat.
    typedef struct packed {
        logic        stop_done;
        logic        move_rejected;
        logic        up_select;
        logic        drive_on;
        logic [1:0]  motion;
        logic [15:0] position;
    } result_t;

    // Overshoot beyond the compare count, saturated to eight bits.
    function automatic logic [7:0] learn_overshoot(input logic [15:0] count,
                                                   input logic [15:0] cmp);
        logic [15:0] diff;
        diff = count - cmp;
        if (count <= cmp)
            return 8'd0;
        else if (diff[15:8] != 8'd0)
            return 8'hFF;
        else
            return diff[7:0];
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/rapc_core.sv =====
// Next-state and result logic for one command beat of the position controller.
// Depends on rapc_pkg.
`default_nettype none

module rapc_core (
    input  wire rapc_pkg::cfg_t    cfg,
    input  wire rapc_pkg::state_t  cur,
    input  wire logic [2:0]        mode,
    input  wire logic [15:0]       target,
    output rapc_pkg::state_t  nxt,
    output rapc_pkg::result_t res
);
    import rapc_pkg::*;

    logic [15:0] timeout_eff;
    logic [15:0] tgt_max;
    logic [15:0] tgt_clamped;
    logic [15:0] dist_up;
    logic [15:0] dist_down;
    logic [15:0] timer_dec;
    logic [15:0] pulse_inc;
    logic        rejected;
    logic        done;

    // A zero timeout behaves as one tick.
    assign timeout_eff = (cfg.stop_timeout_ms == 16'd0) ? 16'd1 : cfg.stop_timeout_ms;

    // Clamp to the upper limit first, so the lower limit wins when they cross.
    assign tgt_max     = (target > cfg.max_limit) ? cfg.max_limit : target;
    assign tgt_clamped = (tgt_max < cfg.min_limit) ? cfg.min_limit : tgt_max;
    assign dist_up     = tgt_clamped - cur.base_position;
    assign dist_down   = cur.base_position - tgt_clamped;

    assign timer_dec = (cur.coast_timer != 16'd0) ? cur.coast_timer - 16'd1 : 16'd0;
    assign pulse_inc = cur.pulse_count + 16'd1;

    // State update for the command.
    always_comb
    begin
        nxt      = cur;
        rejected = 1'b0;
        done     = 1'b0;
        case (mode_t'(mode))
            MODE_TICK:
            begin
                if (cur.coasting)
                begin
                    nxt.coast_timer = timer_dec;
                    if (timer_dec == 16'd0)
                    begin
                        // Fold the count into the position and learn the overshoot.
                        if (cur.move_dir == DIR_UP)
                        begin
                            nxt.base_position = cur.base_position + cur.pulse_count;
                            nxt.overshoot_up  = learn_overshoot(cur.pulse_count,
                                                                cur.compare_count);
                        end
                        else
                        begin
                            nxt.base_position  = cur.base_position - cur.pulse_count;
                            nxt.overshoot_down = learn_overshoot(cur.pulse_count,
                                                                 cur.compare_count);
                        end
                        nxt.pulse_count = 16'd0;
                        nxt.move_dir    = DIR_IDLE;
                        nxt.coasting    = 1'b0;
                        nxt.coast_timer = 16'd0;
                        done            = 1'b1;
                    end
                end
            end
            MODE_PULSE:
            begin
                if (cur.move_dir != DIR_IDLE)
                begin
                    nxt.pulse_count = pulse_inc;
                    if (!cur.coasting && pulse_inc == cur.compare_count)
                    begin
                        nxt.coasting    = 1'b1;
                        nxt.coast_timer = timeout_eff;
                    end
                end
            end
            MODE_MOVE:
            begin
                if (tgt_clamped != cur.base_position)
                begin
                    if (cur.move_dir != DIR_IDLE)
                        rejected = 1'b1;
                    else if (tgt_clamped > cur.base_position)
                    begin
                        if ({8'd0, cur.overshoot_up} > dist_up)
                            rejected = 1'b1;
                        else
                        begin
                            nxt.compare_count = dist_up - {8'd0, cur.overshoot_up};
                            nxt.move_dir      = DIR_UP;
                        end
                    end
                    else
                    begin
                        if ({8'd0, cur.overshoot_down} > dist_down)
                            rejected = 1'b1;
                        else
                        begin
                            nxt.compare_count = dist_down - {8'd0, cur.overshoot_down};
                            nxt.move_dir      = DIR_DOWN;
                        end
                    end
                    if (!rejected)
                    begin
                        nxt.pulse_count = 16'd0;
                        nxt.coasting    = 1'b0;
                        // Distance equal to the overshoot: coast at once.
                        if (nxt.compare_count == 16'd0)
                        begin
                            nxt.coasting    = 1'b1;
                            nxt.coast_timer = timeout_eff;
                        end
                    end
                end
            end
            MODE_STOP:
            begin
                if (cur.move_dir != DIR_IDLE)
                begin
                    nxt.coasting    = 1'b1;
                    nxt.coast_timer = timeout_eff;
                end
            end
            MODE_LOAD:
            begin
                nxt.base_position = target;
            end
            default:
            begin
                nxt = cur;
            end
        endcase
    end

    // Result built from the updated state.
    always_comb
    begin
        case (nxt.move_dir)
            DIR_UP:   res.position = nxt.base_position + nxt.pulse_count;
            DIR_DOWN: res.position = nxt.base_position - nxt.pulse_count;
            default:  res.position = nxt.base_position;
        endcase
        res.motion        = nxt.move_dir;
        res.drive_on      = (nxt.move_dir != DIR_IDLE) && !nxt.coasting;
        res.up_select     = (nxt.move_dir == DIR_UP) && !nxt.coasting;
        res.move_rejected = rejected;
        res.stop_done     = done;
    end

endmodule

`default_nettype wire

// ===== hw/rtl/relay_actuator_position_control_top.sv =====
// Relay actuator position controller: stream ports, configuration registers,
// controller state and the result register. Depends on rapc_pkg and rapc_core.
// Each accepted command beat yields its result beat from the result register in the next cycle.
// Throughput: one command per cycle; the result register is refilled in the
// cycle it is read, so the input only stalls while a result waits unread.
// Reset (rst_n low, asynchronous): limits 300 and 6100, timeout 1500 ticks,
// position 1200, idle, overshoots zero, no result pending.
`default_nettype none

module relay_actuator_position_control_top (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // Command stream.
    input  wire logic        s_axis_tvalid,
    output      logic        s_axis_tready,
    input  wire logic [15:0] s_axis_tdata,   // [15:0] target
    input  wire logic [2:0]  s_axis_tuser,   // [2:0] mode
    // Result stream.
    output      logic        m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output      logic [23:0] m_axis_tdata,   // [15:0] position, [17:16] motion,
                                             // [18] drive on, [19] up select,
                                             // [20] move_rejected, [21] stop_done
    // Configuration writes.
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_addr,
    input  wire logic [15:0] cfg_data
);
    import rapc_pkg::*;

    cfg_t    cfg_reg;
    state_t  state_reg;
    state_t  state_next;
    result_t res_reg;
    result_t res_next;
    logic    out_valid_reg;
    logic    in_beat;

    assign s_axis_tready = !out_valid_reg || m_axis_tready;
    assign in_beat       = s_axis_tvalid && s_axis_tready;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.min_limit       <= RESET_MIN_LIMIT;
            cfg_reg.max_limit       <= RESET_MAX_LIMIT;
            cfg_reg.stop_timeout_ms <= RESET_TIMEOUT;
        end
        else if (cfg_we)
        begin
            case (reg_idx_t'(cfg_addr))
                REG_MIN_LIMIT: cfg_reg.min_limit       <= cfg_data;
                REG_MAX_LIMIT: cfg_reg.max_limit       <= cfg_data;
                REG_TIMEOUT:   cfg_reg.stop_timeout_ms <= cfg_data;
                default:       cfg_reg                 <= cfg_reg;
            endcase
        end
    end

    // Command evaluation.
    rapc_core u_core (
        .cfg    (cfg_reg),
        .cur    (state_reg),
        .mode   (s_axis_tuser),
        .target (s_axis_tdata),
        .nxt    (state_next),
        .res    (res_next)
    );

    // Controller state, updated on each accepted command.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.base_position  <= RESET_POSITION;
            state_reg.pulse_count    <= 16'd0;
            state_reg.compare_count  <= 16'd0;
            state_reg.move_dir       <= DIR_IDLE;
            state_reg.coasting       <= 1'b0;
            state_reg.coast_timer    <= 16'd0;
            state_reg.overshoot_up   <= 8'd0;
            state_reg.overshoot_down <= 8'd0;
        end
        else if (in_beat)
        begin
            state_reg <= state_next;
        end
    end

    // Result valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (in_beat)
            out_valid_reg <= 1'b1;
        else if (m_axis_tready)
            out_valid_reg <= 1'b0;
    end

    // Result payload.
    always_ff @(posedge clk)
    begin
        if (in_beat)
            res_reg <= res_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {2'b00, res_reg};

endmodule

`default_nettype wire

// ===== tb/tb_relay_actuator_position_control_top.sv =====
// Self-checking testbench for relay_actuator_position_control_top.
// Drives command beats and register writes, and predicts every result beat from its
// own model of the controller. Depends on rapc_pkg and the RTL of the top level only.
module tb_relay_actuator_position_control_top;
    timeunit 1ns;
    timeprecision 1ps;

    import rapc_pkg::*;

    // Unused command codes; they must leave the state untouched.
    localparam logic [2:0] MODE_SPARE_FIRST = 3'd5;
    localparam logic [2:0] MODE_SPARE_LAST  = 3'd7;

    // One line of the directed plan: a command beat or a register write.
    typedef struct {
        bit          is_write;
        logic [2:0]  code;
        logic [15:0] value;
        bit          typed;
        result_t     want;
    } plan_row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata = '0;      // [15:0] target
    logic [2:0]  s_axis_tuser = '0;      // [2:0] mode
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [23:0] m_axis_tdata;           // [15:0] position, [17:16] motion, [18] drive on,
                                         // [19] up select, [20] move_rejected, [21] stop_done
    logic        cfg_we = 1'b0;
    logic [1:0]  cfg_addr = '0;
    logic [15:0] cfg_data = '0;

    // Predicted controller configuration and state.
    logic [15:0] lim_lo = RESET_MIN_LIMIT;
    logic [15:0] lim_hi = RESET_MAX_LIMIT;
    logic [15:0] coast_ticks = RESET_TIMEOUT;
    logic [15:0] home_pos = RESET_POSITION;
    logic [15:0] pulses = '0;
    logic [15:0] pulses_to_stop = '0;
    dir_t        heading = DIR_IDLE;
    logic        in_coast = 1'b0;
    logic [15:0] coast_left = '0;
    logic [7:0]  overrun_up = '0;
    logic [7:0]  overrun_down = '0;

    result_t     expected_status[$];
    plan_row_t   plan[$];
    int          mismatches = 0;
    int          beats_seen = 0;
    int          gap_odds = 0;
    int          stall_odds = 0;
    int          rx_hold = 0;

    relay_actuator_position_control_top dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_we        (cfg_we),
        .cfg_addr      (cfg_addr),
        .cfg_data      (cfg_data)
    );

    // 125 MHz clock.
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Run limit, far beyond the slowest correct run.
    initial
    begin
        #2_000_000;
        $display("tb_relay_actuator_position_control_top failed");
        $finish;
    end

    // Releasing the relays: the coast runs for the configured ticks, zero counting as one.
    function automatic void start_coasting();
        in_coast = 1'b1;
        coast_left = (coast_ticks == 16'd0) ? 16'd1 : coast_ticks;
    endfunction

    // Applies one command to the predicted state and returns the status it reports.
    function automatic result_t advance_actuator(input logic [2:0] cmd, input logic [15:0] arg);
        result_t     r;
        logic [15:0] goal;
        logic [15:0] excess;
        logic [7:0]  learned;
        r = '0;
        case (cmd)
            MODE_TICK:
            begin
                if (in_coast)
                begin
                    if (coast_left != 16'd0)
                        coast_left = coast_left - 16'd1;
                    // End of the coast: fold the count in and learn the overrun.
                    if (coast_left == 16'd0)
                    begin
                        excess = pulses - pulses_to_stop;
                        if (pulses <= pulses_to_stop)
                            learned = 8'd0;
                        else if (excess > 16'd255)
                            learned = 8'hFF;
                        else
                            learned = excess[7:0];
                        if (heading == DIR_UP)
                        begin
                            home_pos = home_pos + pulses;
                            overrun_up = learned;
                        end
                        else
                        begin
                            home_pos = home_pos - pulses;
                            overrun_down = learned;
                        end
                        pulses = '0;
                        heading = DIR_IDLE;
                        in_coast = 1'b0;
                        coast_left = '0;
                        r.stop_done = 1'b1;
                    end
                end
            end
            MODE_PULSE:
            begin
                if (heading != DIR_IDLE)
                begin
                    pulses = pulses + 16'd1;
                    if (!in_coast && pulses == pulses_to_stop)
                        start_coasting();
                end
            end
            MODE_MOVE:
            begin
                // Upper clamp first, so the lower limit wins when the two cross.
                goal = arg;
                if (goal > lim_hi)
                    goal = lim_hi;
                if (goal < lim_lo)
                    goal = lim_lo;
                if (goal == home_pos)
                    r.move_rejected = 1'b0;
                else if (heading != DIR_IDLE)
                    r.move_rejected = 1'b1;
                else if (goal > home_pos && overrun_up > goal - home_pos)
                    r.move_rejected = 1'b1;
                else if (goal < home_pos && overrun_down > home_pos - goal)
                    r.move_rejected = 1'b1;
                else
                begin
                    if (goal > home_pos)
                    begin
                        pulses_to_stop = goal - home_pos - overrun_up;
                        heading = DIR_UP;
                    end
                    else
                    begin
                        pulses_to_stop = home_pos - goal - overrun_down;
                        heading = DIR_DOWN;
                    end
                    pulses = '0;
                    in_coast = 1'b0;
                    if (pulses_to_stop == 16'd0)
                        start_coasting();
                end
            end
            MODE_STOP:
            begin
                if (heading != DIR_IDLE)
                    start_coasting();
            end
            MODE_LOAD:
                home_pos = arg;
            default: ;
        endcase
        if (heading == DIR_UP)
            r.position = home_pos + pulses;
        else if (heading == DIR_DOWN)
            r.position = home_pos - pulses;
        else
            r.position = home_pos;
        r.motion = heading;
        r.drive_on = (heading != DIR_IDLE) && !in_coast;
        r.up_select = (heading == DIR_UP) && !in_coast;
        return r;
    endfunction

    // Chooses a random command, mostly well-formed move sequences for the current state.
    function automatic void pick_command(output logic [2:0] cmd, output logic [15:0] arg);
        int          roll;
        logic [15:0] near;
        roll = $urandom_range(0, 99);
        near = $urandom_range(0, 1) ? home_pos + 16'($urandom_range(1, 24))
                                    : home_pos - 16'($urandom_range(1, 24));
        arg = 16'($urandom_range(0, 65535));
        if (heading == DIR_IDLE)
        begin
            if (roll < 50)
            begin
                cmd = MODE_MOVE;
                arg = near;
            end
            else if (roll < 58)
                cmd = MODE_MOVE;
            else if (roll < 66)
            begin
                cmd = MODE_LOAD;
                if (roll < 62)
                    arg = near;
            end
            else if (roll < 76)
                cmd = MODE_TICK;
            else if (roll < 84)
                cmd = MODE_PULSE;
            else if (roll < 90)
                cmd = MODE_STOP;
            else
                cmd = 3'($urandom_range(MODE_SPARE_FIRST, MODE_SPARE_LAST));
        end
        else if (!in_coast)
        begin
            if (roll < 70)
                cmd = MODE_PULSE;
            else if (roll < 78)
                cmd = MODE_STOP;
            else if (roll < 85)
                cmd = MODE_TICK;
            else if (roll < 92)
            begin
                cmd = MODE_MOVE;
                if (roll < 89)
                    arg = near;
            end
            else if (roll < 95)
                cmd = MODE_LOAD;
            else
                cmd = 3'($urandom_range(MODE_SPARE_FIRST, MODE_SPARE_LAST));
        end
        else
        begin
            if (roll < 45)
                cmd = MODE_TICK;
            else if (roll < 75)
                cmd = MODE_PULSE;
            else if (roll < 83)
                cmd = MODE_STOP;
            else if (roll < 90)
                cmd = MODE_MOVE;
            else if (roll < 93)
                cmd = MODE_LOAD;
            else
                cmd = 3'($urandom_range(MODE_SPARE_FIRST, MODE_SPARE_LAST));
        end
    endfunction

    function automatic result_t status(input logic [15:0] pos, input dir_t motion,
                                       input logic on, input logic up,
                                       input logic rej, input logic done);
        return {done, rej, up, on, motion, pos};
    endfunction

    function automatic plan_row_t command_row(input logic [2:0] cmd, input logic [15:0] arg,
                                              input bit typed = 1'b0,
                                              input result_t want = '0);
        plan_row_t row;
        row.is_write = 1'b0;
        row.code = cmd;
        row.value = arg;
        row.typed = typed;
        row.want = want;
        return row;
    endfunction

    function automatic plan_row_t register_row(input reg_idx_t idx, input logic [15:0] val);
        plan_row_t row;
        row.is_write = 1'b1;
        row.code = {1'b0, idx};
        row.value = val;
        row.typed = 1'b0;
        row.want = '0;
        return row;
    endfunction

    // One mismatch: print it and count it.
    task automatic report_mismatch(input string msg);
        $display("[%0t] beat %0d: %s", $realtime, beats_seen, msg);
        mismatches++;
    endtask

    task automatic check_field(input string name, input logic [15:0] got,
                               input logic [15:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s is %0h, expected %0h", name, got, want));
    endtask

    // Sends one command beat and records its expected status once it is taken.
    task automatic send_command(input logic [2:0] cmd, input logic [15:0] arg,
                                input bit typed = 1'b0, input result_t want = '0);
        result_t predicted;
        if (gap_odds != 0 && $urandom_range(0, gap_odds) == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= cmd;
        s_axis_tdata <= arg;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        predicted = advance_actuator(cmd, arg);
        expected_status.push_back(typed ? want : predicted);
        @(negedge clk);
    endtask

    // Hold the sender until every expected status beat has come back.
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        while (expected_status.size() != 0)
            @(negedge clk);
    endtask

    // Register writes only happen with nothing in flight.
    task automatic write_register(input reg_idx_t idx, input logic [15:0] val);
        drain_results();
        cfg_we <= 1'b1;
        cfg_addr <= idx;
        cfg_data <= val;
        @(negedge clk);
        cfg_we <= 1'b0;
        case (idx)
            REG_MIN_LIMIT: lim_lo = val;
            REG_MAX_LIMIT: lim_hi = val;
            REG_TIMEOUT:   coast_ticks = val;
            default: ;
        endcase
        @(negedge clk);
    endtask

    // Result side: random stall bursts that hold m_axis_tready low.
    always @(negedge clk)
    begin
        if (rx_hold > 0)
        begin
            rx_hold = rx_hold - 1;
            m_axis_tready <= 1'b0;
        end
        else if (stall_odds != 0 && $urandom_range(0, stall_odds) == 0)
        begin
            rx_hold = $urandom_range(0, 6);
            m_axis_tready <= 1'b0;
        end
        else
            m_axis_tready <= 1'b1;
    end

    // Compare each result beat with the oldest expectation, field by field.
    always @(posedge clk)
    begin
        result_t seen;
        result_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            seen = result_t'(m_axis_tdata[21:0]);
            if (expected_status.size() == 0)
                report_mismatch($sformatf("unexpected result beat %0h", m_axis_tdata));
            else
            begin
                want = expected_status.pop_front();
                check_field("position", seen.position, want.position);
                check_field("motion", 16'(seen.motion), 16'(want.motion));
                check_field("drive on", 16'(seen.drive_on), 16'(want.drive_on));
                check_field("up select", 16'(seen.up_select), 16'(want.up_select));
                check_field("move_rejected", 16'(seen.move_rejected),
                            16'(want.move_rejected));
                check_field("stop_done", 16'(seen.stop_done), 16'(want.stop_done));
            end
            beats_seen++;
        end
    end

    // Stimulus: directed plan, then random phases under changing limits and timeouts.
    initial
    begin
        logic [2:0]  cmd;
        logic [15:0] arg;
        logic [15:0] lo;
        int          phase_len;

        // Reset values, idle commands and the ignored cases.
        plan.push_back(command_row(MODE_TICK, 16'd0, 1'b1,
                                   status(16'd1200, DIR_IDLE, 1'b0, 1'b0, 1'b0, 1'b0)));
        plan.push_back(command_row(MODE_PULSE, 16'hFFFF, 1'b1,
                                   status(16'd1200, DIR_IDLE, 1'b0, 1'b0, 1'b0, 1'b0)));
        plan.push_back(command_row(MODE_STOP, 16'd0, 1'b1,
                                   status(16'd1200, DIR_IDLE, 1'b0, 1'b0, 1'b0, 1'b0)));
        plan.push_back(command_row(MODE_SPARE_FIRST, 16'hFFFF, 1'b1,
                                   status(16'd1200, DIR_IDLE, 1'b0, 1'b0, 1'b0, 1'b0)));
        plan.push_back(command_row(MODE_SPARE_LAST, 16'd0, 1'b1,
                                   status(16'd1200, DIR_IDLE, 1'b0, 1'b0, 1'b0, 1'b0)));
        plan.push_back(command_row(MODE_MOVE, 16'd1200, 1'b1,
                                   status(16'd1200, DIR_IDLE, 1'b0, 1'b0, 1'b0, 1'b0)));
        // Down move clamped to the lower limit, then a refused move and a no-op move.
        plan.push_back(command_row(MODE_MOVE, 16'd0, 1'b1,
                                   status(16'd1200, DIR_DOWN, 1'b1, 1'b0, 1'b0, 1'b0)));
        plan.push_back(command_row(MODE_MOVE, 16'hFFFF, 1'b1,
                                   status(16'd1200, DIR_DOWN, 1'b1, 1'b0, 1'b1, 1'b0)));
        plan.push_back(command_row(MODE_MOVE, 16'd1200, 1'b1,
                                   status(16'd1200, DIR_DOWN, 1'b1, 1'b0, 1'b0, 1'b0)));
        // Load while moving, stop, counting during the coast and a restarted coast.
        plan.push_back(command_row(MODE_PULSE, 16'd0));
        plan.push_back(command_row(MODE_LOAD, 16'hFFFF));
        plan.push_back(command_row(MODE_PULSE, 16'd0));
        plan.push_back(command_row(MODE_STOP, 16'd0));
        plan.push_back(command_row(MODE_PULSE, 16'd0));
        plan.push_back(register_row(REG_TIMEOUT, 16'd0));
        plan.push_back(command_row(MODE_STOP, 16'd0));
        plan.push_back(command_row(MODE_TICK, 16'd0));
        // Full range, an up move that overruns and learns its overshoot, wrapping past top.
        plan.push_back(register_row(REG_MIN_LIMIT, 16'd0));
        plan.push_back(register_row(REG_MAX_LIMIT, 16'hFFFF));
        plan.push_back(command_row(MODE_MOVE, 16'hFFFD));
        plan.push_back(command_row(MODE_PULSE, 16'd0));
        plan.push_back(command_row(MODE_PULSE, 16'd0));
        plan.push_back(command_row(MODE_PULSE, 16'd0));
        plan.push_back(command_row(MODE_PULSE, 16'd0));
        plan.push_back(command_row(MODE_TICK, 16'd0));
        // Learned overshoot larger than the distance, then equal to it.
        plan.push_back(command_row(MODE_LOAD, 16'd0));
        plan.push_back(command_row(MODE_MOVE, 16'd1, 1'b1,
                                   status(16'd0, DIR_IDLE, 1'b0, 1'b0, 1'b1, 1'b0)));
        plan.push_back(command_row(MODE_MOVE, 16'd3));
        plan.push_back(command_row(MODE_TICK, 16'd0));

        repeat (9) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        gap_odds = 3;
        stall_odds = 3;
        foreach (plan[i])
        begin
            if (plan[i].is_write)
                write_register(reg_idx_t'(plan[i].code[1:0]), plan[i].value);
            else
                send_command(plan[i].code, plan[i].value, plan[i].typed, plan[i].want);
        end

        for (int ph = 0; ph < 10; ph++)
        begin
            phase_len = 68;
            case (ph)
                0:
                begin
                    write_register(REG_MIN_LIMIT, 16'd0);
                    write_register(REG_MAX_LIMIT, 16'hFFFF);
                    write_register(REG_TIMEOUT, 16'd3);
                end
                1:
                begin
                    // Crossed limits: every move lands on the lower limit.
                    write_register(REG_MIN_LIMIT, 16'd5000);
                    write_register(REG_MAX_LIMIT, 16'd100);
                    write_register(REG_TIMEOUT, 16'd1);
                end
                2:
                begin
                    write_register(REG_MIN_LIMIT, 16'd100);
                    write_register(REG_MAX_LIMIT, 16'd900);
                    write_register(REG_TIMEOUT, 16'd0);
                end
                3:
                begin
                    write_register(REG_MIN_LIMIT, 16'hFFFF);
                    write_register(REG_MAX_LIMIT, 16'hFFFF);
                    write_register(REG_TIMEOUT, 16'hFFFF);
                    phase_len = 40;
                end
                4:
                begin
                    write_register(REG_MIN_LIMIT, RESET_MIN_LIMIT);
                    write_register(REG_MAX_LIMIT, RESET_MAX_LIMIT);
                    write_register(REG_TIMEOUT, 16'd2);
                end
                9:
                begin
                    write_register(REG_MIN_LIMIT, 16'd0);
                    write_register(REG_MAX_LIMIT, 16'hFFFF);
                    write_register(REG_TIMEOUT, 16'd5);
                end
                default:
                begin
                    lo = 16'($urandom_range(0, 30000));
                    write_register(REG_MIN_LIMIT, lo);
                    write_register(REG_MAX_LIMIT, lo + 16'($urandom_range(0, 30000)));
                    write_register(REG_TIMEOUT, 16'($urandom_range(1, 12)));
                end
            endcase
            // Idling varies by phase; one phase and the final one run flat out.
            if (ph == 4 || ph == 9)
            begin
                gap_odds = 0;
                stall_odds = 0;
            end
            else
            begin
                gap_odds = $urandom_range(2, 6);
                stall_odds = $urandom_range(2, 6);
            end
            repeat (phase_len)
            begin
                pick_command(cmd, arg);
                send_command(cmd, arg);
            end
        end

        drain_results();
        repeat (4) @(negedge clk);
        if (mismatches == 0)
            $display("tb_relay_actuator_position_control_top passed");
        else
            $display("tb_relay_actuator_position_control_top failed");
        $finish;
    end

endmodule
